// ===== rtl/pcd_pkg.sv =====
// Package for the polar to cartesian (degrees) unit.
// Holds datapath widths, CORDIC gain and arctangent constants, and divider constants.
// No dependencies.
`default_nettype none

package pcd_pkg;

    // Default module parameters
    localparam int CORDIC_STAGES_DEF = 18;
    localparam int FRAC_BITS_DEF     = 16;

    // CORDIC datapath: 16 guard bits below the output fraction, 50 bits hold any value
    localparam int DP_W         = 50;
    localparam int GUARD_BITS   = 16;
    localparam int ATAN_ENTRIES = 30;

    // Gain compensation K = 0.60725293500888 scaled by 2^32
    localparam logic [31:0] GAIN_K = 32'd2608131496;

    // atan(2^-i) in binary angle units, 2^32 per full turn
    localparam logic [29:0] ATAN_TAB [ATAN_ENTRIES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
        30'd20,        30'd10,        30'd5,         30'd3,        30'd1
    };

    // Quadrant codes from the top two bits of the binary angle
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    // Degrees to binary angle: 2^32 = 360 * 11930464 + 256
    localparam logic [23:0] TURN_PER_DEG = 24'd11930464;
    localparam int          DEG_RESIDUE  = 256;
    localparam int          DEG_HALF     = 180;

    // Divide by 45 of a 30-bit value: floor(2^36 / 45), shift 36
    localparam int          W8_W      = 30;
    localparam int          R45_W     = 31;
    localparam int          R45_SHIFT = 36;
    localparam logic [30:0] R45       = 31'd1527099483;

endpackage

`default_nettype wire

// ===== rtl/polar_to_cartesian_degrees_unit.sv =====
// Polar to cartesian conversion with angle in degrees, pipelined CORDIC.
// Stages: offset, divide by 360, mod 360, binary angle, quotient fix, CORDIC, fold, round, output.
// Throughput: one item per cycle while the skid is empty; the skid register absorbs one stall.
// Reset (synchronous, active low) clears all valid bits and round mode.
// Depends on pcd_pkg.
`default_nettype none

module polar_to_cartesian_degrees_unit #(
    parameter int CORDIC_STAGES = pcd_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = pcd_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [31:0] i_magnitude,
    input  wire logic signed [31:0] i_angle_deg,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_x_coord,
    output logic signed [31:0]      o_y_coord
);

    localparam int DPW = pcd_pkg::DP_W;
    localparam int GB  = pcd_pkg::GUARD_BITS;

    // Angle range reduction constants
    localparam longint TURN     = longint'(360) << FRAC_BITS;
    localparam longint TURN_CNT = ((longint'(1) << 31) + TURN - 1) / TURN;
    localparam longint MT       = TURN_CNT * TURN;
    localparam int     UW       = $clog2((longint'(1) << 31) + MT);
    localparam int     HW       = UW - FRAC_BITS;
    localparam int     DW       = (HW > 10) ? HW : 10;
    localparam int     XW1      = DW - 3;
    localparam int     S1       = XW1 + 6;
    localparam int     R1W      = XW1 + 1;
    localparam int     P1W      = XW1 + R1W;
    localparam int     QW       = P1W - S1;
    localparam logic [R1W-1:0] R1_V = R1W'((longint'(1) << S1) / 45);
    localparam int     SH       = 32 - FRAC_BITS;
    localparam int     P2W      = pcd_pkg::W8_W + pcd_pkg::R45_W;
    localparam int     Q2W      = P2W - pcd_pkg::R45_SHIFT;

    // Output rounding widths
    localparam int RT  = FRAC_BITS + GB;
    localparam int KAW = DPW - RT;
    localparam int NW  = DPW - GB;
    localparam int KW  = NW + 1;

    // Stage indexes
    localparam int ST_CRD = 5;
    localparam int ST_QD  = ST_CRD + CORDIC_STAGES;
    localparam int ST_F1  = ST_QD + 1;
    localparam int L      = ST_F1 + 1;
    localparam int NSTG   = L + 1;

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [NW-1:0] norm_rnd(input logic signed [DPW-1:0] v);
        logic signed [DPW-1:0] t;
        t = v + DPW'(longint'(1) << (GB - 1));
        return t[DPW-1:GB];
    endfunction

    function automatic logic [KAW-1:0] whole_rnd(input logic signed [DPW-1:0] v);
        logic [DPW-1:0] a;
        logic [DPW-1:0] t;
        a = v[DPW-1] ? DPW'(-v) : DPW'(v);
        t = a + DPW'(longint'(1) << (RT - 1));
        return t[DPW-1:RT];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [KW-1:0] v);
        logic signed [31:0] r;
        if (v > KW'(32'sh7fff_ffff)) begin
            r = 32'sh7fff_ffff;
        end else if (v < KW'(32'sh8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] finish(input logic rm,
                                                  input logic signed [NW-1:0] nv,
                                                  input logic [KAW-1:0] ka,
                                                  input logic neg);
        logic signed [KW-1:0] kv;
        if (rm) begin
            kv = KW'({ka, {FRAC_BITS{1'b0}}});
            if (neg) begin
                kv = -kv;
            end
        end else begin
            kv = KW'(nv);
        end
        return sat32(kv);
    endfunction

    // ---------------------------------------------------------------- control
    logic            r_round_mode;
    logic [NSTG-1:0] r_vld;
    logic            r_skid_vld;
    logic signed [31:0] r_skid_x, r_skid_y;
    logic            adv;

    // Pipeline moves as a whole while the skid register is empty
    assign adv        = !r_skid_vld;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_round_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------- stage 0: offset angle
    logic [UW-1:0]      r0_u;
    logic signed [31:0] r0_mag;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_u   <= UW'(i_angle_deg) + UW'(MT);
            r0_mag <= i_magnitude;
        end
    end

    // ---------------------------------------------------------------- stage 1: divide by 360
    logic [DW-1:0]        h;
    logic [P1W-1:0]       r1_prod;
    logic [9:0]           r1_h10;
    logic [FRAC_BITS-1:0] r1_low;
    logic signed [64:0]   r1_pm;

    assign h = DW'(r0_u[UW-1:FRAC_BITS]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_prod <= P1W'(h[DW-1:3]) * P1W'(R1_V);
            r1_h10  <= h[9:0];
            r1_low  <= r0_u[FRAC_BITS-1:0];
            r1_pm   <= 65'(r0_mag) * $signed(65'(pcd_pkg::GAIN_K));
        end
    end

    // ---------------------------------------------------------------- stage 2: remainder mod 360
    logic [QW-1:0]          q0;
    logic [9:0]             d360;
    logic [8:0]             n2_rem;
    logic [8:0]             r2_rem;
    logic [FRAC_BITS-1:0]   r2_low;
    logic signed [DPW-1:0]  r2_x0;

    always_comb begin
        q0     = r1_prod[P1W-1:S1];
        d360   = r1_h10 - 10'(10'(q0) * 10'd360);
        n2_rem = (d360 >= 10'd360) ? 9'(d360 - 10'd360) : 9'(d360);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_rem <= n2_rem;
            r2_low <= r1_low;
            r2_x0  <= DPW'($signed(r1_pm[64:GB]));
        end
    end

    // ---------------------------------------------------------------- stage 3: binary angle, divide
    logic [32:0]                  w;
    logic [P2W-1:0]               r3_prod;
    logic [6:0]                   r3_w8lo;
    logic [31:0]                  r3_base;
    logic signed [DPW-1:0]        r3_x0;

    // Remainder part of rem * 2^32 plus fraction part, rounded half up
    assign w = (33'(r2_rem) * 33'(pcd_pkg::DEG_RESIDUE)) + {1'b0, r2_low, {SH{1'b0}}}
             + 33'(pcd_pkg::DEG_HALF);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_prod <= P2W'(w[32:3]) * P2W'(pcd_pkg::R45);
            r3_w8lo <= w[9:3];
            r3_base <= 32'(r2_rem) * 32'(pcd_pkg::TURN_PER_DEG);
            r3_x0   <= r2_x0;
        end
    end

    // ---------------------------------------------------------------- stage 4: quotient correction
    logic [Q2W-1:0]        q2;
    logic [6:0]            d45;
    logic [31:0]           theta;
    logic [1:0]            r4_quad;
    logic signed [31:0]    r4_z;
    logic signed [DPW-1:0] r4_x0;

    always_comb begin
        q2    = r3_prod[P2W-1:pcd_pkg::R45_SHIFT];
        d45   = r3_w8lo - 7'(7'(q2) * 7'd45);
        theta = r3_base + 32'(q2) + ((d45 >= 7'd45) ? 32'd1 : 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_quad <= theta[31:30];
            r4_z    <= $signed({2'b00, theta[29:0]});
            r4_x0   <= r3_x0;
        end
    end

    // ---------------------------------------------------------------- CORDIC rotation stages
    logic signed [DPW-1:0] r_cx [CORDIC_STAGES];
    logic signed [DPW-1:0] r_cy [CORDIC_STAGES];
    logic signed [31:0]    r_cz [CORDIC_STAGES];
    logic [1:0]            r_cq [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_crd
        logic signed [DPW-1:0] px, py;
        logic signed [31:0]    pz;
        logic [1:0]            pq;

        if (k == 0) begin : g_first
            assign px = r4_x0;
            assign py = '0;
            assign pz = r4_z;
            assign pq = r4_quad;
        end else begin : g_next
            assign px = r_cx[k-1];
            assign py = r_cy[k-1];
            assign pz = r_cz[k-1];
            assign pq = r_cq[k-1];
        end

        // Rotate toward zero residual angle
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!pz[31]) begin
                    r_cx[k] <= px - (py >>> k);
                    r_cy[k] <= py + (px >>> k);
                    r_cz[k] <= pz - $signed({2'b00, pcd_pkg::ATAN_TAB[k]});
                end else begin
                    r_cx[k] <= px + (py >>> k);
                    r_cy[k] <= py - (px >>> k);
                    r_cz[k] <= pz + $signed({2'b00, pcd_pkg::ATAN_TAB[k]});
                end
                r_cq[k] <= pq;
            end
        end
    end

    // ---------------------------------------------------------------- quadrant fold
    logic signed [DPW-1:0] c_fin, s_fin;
    logic signed [DPW-1:0] r_qx, r_qy;

    assign c_fin = r_cx[CORDIC_STAGES-1];
    assign s_fin = r_cy[CORDIC_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (r_cq[CORDIC_STAGES-1])
                pcd_pkg::QUAD_I: begin
                    r_qx <= c_fin;
                    r_qy <= s_fin;
                end
                pcd_pkg::QUAD_II: begin
                    r_qx <= -s_fin;
                    r_qy <= c_fin;
                end
                pcd_pkg::QUAD_III: begin
                    r_qx <= -c_fin;
                    r_qy <= -s_fin;
                end
                default: begin
                    r_qx <= s_fin;
                    r_qy <= -c_fin;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- rounding, both modes
    logic signed [NW-1:0] r_nx, r_ny;
    logic [KAW-1:0]       r_kx, r_ky;
    logic                 r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nx <= norm_rnd(r_qx);
            r_ny <= norm_rnd(r_qy);
            r_kx <= whole_rnd(r_qx);
            r_ky <= whole_rnd(r_qy);
            r_sx <= r_qx[DPW-1];
            r_sy <= r_qy[DPW-1];
        end
    end

    // ---------------------------------------------------------------- output stage and skid
    logic signed [31:0] r_ox, r_oy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ox <= finish(r_round_mode, r_nx, r_kx, r_sx);
            r_oy <= finish(r_round_mode, r_ny, r_ky, r_sy);
        end
    end

    // Catch the output item when it is not taken while the pipeline moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            r_skid_vld <= !i_out_ready;
        end else begin
            r_skid_vld <= r_vld[L] && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_x <= r_ox;
            r_skid_y <= r_oy;
        end
    end

    assign o_out_valid = r_skid_vld || r_vld[L];
    assign o_x_coord   = r_skid_vld ? r_skid_x : r_ox;
    assign o_y_coord   = r_skid_vld ? r_skid_y : r_oy;

    // ---------------------------------------------------------------- assertions
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_vld[1] |=> r2_rem < 9'd360)
        else $error("angle remainder out of range");

    a_in_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted item not captured");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_vld && r_vld[L] && !i_out_ready |=> r_skid_vld && !o_in_ready)
        else $error("stalled output item not held in skid");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_out_ready |=> r_skid_vld && $stable(r_skid_x) && $stable(r_skid_y))
        else $error("skid item changed while stalled");

endmodule

`default_nettype wire
